>>> hdl/psvd_pkg.sv
// ----------------------------------------------------------------------------
// psvd_pkg
// Shared types and constants of the program stream video demultiplexer.
// ----------------------------------------------------------------------------
package psvd_pkg;

    // Parser phases, one-hot.
    typedef enum logic [11:0] {
        PH_HUNT    = 12'b0000_0000_0001,
        PH_CODE    = 12'b0000_0000_0010,
        PH_PACK    = 12'b0000_0000_0100,
        PH_STUFF   = 12'b0000_0000_1000,
        PH_LEN_HI  = 12'b0000_0001_0000,
        PH_LEN_LO  = 12'b0000_0010_0000,
        PH_FLAG1   = 12'b0000_0100_0000,
        PH_FLAG2   = 12'b0000_1000_0000,
        PH_HLEN    = 12'b0001_0000_0000,
        PH_HDR     = 12'b0010_0000_0000,
        PH_PAYLOAD = 12'b0100_0000_0000,
        PH_SKIP    = 12'b1000_0000_0000
    } phase_t;

    // Stream codes with a fixed meaning.
    localparam logic [7:0] CODE_PACK   = 8'hBA;
    localparam logic [7:0] CODE_SYSHDR = 8'hBB;
    localparam logic [7:0] CODE_MAP    = 8'hBC;

    // Fixed byte counts of the headers.
    localparam logic [16:0] PACK_SKIP      = 17'd9;
    localparam logic [16:0] NOEXT_EXTRA    = 17'd5;
    localparam logic [16:0] PES_HDR_FIXED  = 17'd3;

    // Configuration registers.
    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIDEO_CODE_MASK  = 1'b0,
        REG_VIDEO_CODE_MATCH = 1'b1
    } cfg_reg_t;
    localparam logic [7:0] VIDEO_CODE_RESET = 8'hE0;

endpackage

>>> hdl/program_stream_video_demux.sv
// ----------------------------------------------------------------------------
// program_stream_video_demux
// Extracts the payload bytes of selected video PES packets from a program
// stream that arrives one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one stream byte per transfer in s_tdata, with s_tlast
//   set on the last byte of a buffer; after that byte the parser drops any
//   partial packet and hunts for a start code again. The master side gives
//   one payload byte per transfer: m_tdata holds the byte and stream code, a
//   first-byte flag is in m_tuser and the last-byte flag in m_tlast.
//   The cfg port selects packets: video_code_mask and video_code_match, both
//   0xE0 after reset, are to be written by the user only while the block is
//   idle; the block itself does not enforce this. Throughput is one byte per
//   clock while the receiver does not stall. A byte waits in the input
//   register, is parsed by the single-step state logic and lands in the
//   output register, from which it is offered on m_tvalid. The parse step
//   of one byte is set by the length compare and the 17-bit down counter.
//   Reset puts the parser in hunting with no packet pending and empties both
//   registers. When the receiver stalls with a result waiting, the input
//   register still fills once, then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
module program_stream_video_demux (
    input  logic        clk,
    input  logic        rst_n,
    // Stream input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    input  logic        s_tlast,     // chunk_last
    // Payload output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [7:0] out_byte, [15:8] out_stream_code
    output logic        m_tuser,     // payload_first
    output logic        m_tlast,     // payload_last
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [psvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers.
    logic [7:0] code_mask_reg;
    logic [7:0] code_match_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state.
    psvd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] window_reg, window_next;
    logic [16:0] skip_left_reg, skip_left_next;
    logic [15:0] pkt_len_reg, pkt_len_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] pay_left_reg, pay_left_next;
    logic        first_pend_reg, first_pend_next;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_code_reg;
    logic        out_first_reg;
    logic        out_last_reg;

    logic        advance;
    logic        proc;
    logic        emit;
    logic [16:0] skip_dec;
    logic [16:0] hdr_total;
    logic [16:0] len_ext;
    logic [15:0] pay_from_hlen;
    logic        code_selected;

    // Handshake: the output register frees up when empty or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_code_reg, out_byte_reg};
    assign m_tuser  = out_first_reg;
    assign m_tlast  = out_last_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_mask_reg  <= psvd_pkg::VIDEO_CODE_RESET;
            code_match_reg <= psvd_pkg::VIDEO_CODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psvd_pkg::REG_VIDEO_CODE_MASK:  code_mask_reg  <= cfg_data;
                psvd_pkg::REG_VIDEO_CODE_MATCH: code_match_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Shared arithmetic of the parse step.
    assign skip_dec      = (skip_left_reg != 17'd0) ? (skip_left_reg - 17'd1) : skip_left_reg;
    assign len_ext       = {1'b0, pkt_len_reg};
    assign hdr_total     = {9'd0, in_byte_reg} + psvd_pkg::PES_HDR_FIXED;
    assign pay_from_hlen = (len_ext >= hdr_total) ? 16'(len_ext - hdr_total) : 16'd0;
    assign code_selected = (code_reg != psvd_pkg::CODE_SYSHDR)
                        && (code_reg != psvd_pkg::CODE_MAP)
                        && ((code_reg & code_mask_reg) == code_match_reg);

    // One parse step per byte.
    always_comb
    begin
        phase_next      = phase_reg;
        window_next     = window_reg;
        skip_left_next  = skip_left_reg;
        pkt_len_next    = pkt_len_reg;
        code_next       = code_reg;
        pay_left_next   = pay_left_reg;
        first_pend_next = first_pend_reg;
        emit            = 1'b0;

        case (phase_reg)
            psvd_pkg::PH_CODE:
            begin
                code_next = in_byte_reg;
                if (in_byte_reg == psvd_pkg::CODE_PACK)
                begin
                    skip_left_next = psvd_pkg::PACK_SKIP;
                    phase_next     = psvd_pkg::PH_PACK;
                end
                else
                begin
                    phase_next = psvd_pkg::PH_LEN_HI;
                end
            end
            psvd_pkg::PH_PACK:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 17'd0)
                begin
                    phase_next = psvd_pkg::PH_STUFF;
                end
            end
            psvd_pkg::PH_STUFF:
            begin
                if (in_byte_reg[2:0] == 3'd0)
                begin
                    phase_next  = psvd_pkg::PH_HUNT;
                    window_next = 16'hFFFF;
                end
                else
                begin
                    skip_left_next = {14'd0, in_byte_reg[2:0]};
                    phase_next     = psvd_pkg::PH_SKIP;
                end
            end
            psvd_pkg::PH_LEN_HI:
            begin
                pkt_len_next = {in_byte_reg, 8'd0};
                phase_next   = psvd_pkg::PH_LEN_LO;
            end
            psvd_pkg::PH_LEN_LO:
            begin
                pkt_len_next = {pkt_len_reg[15:8], in_byte_reg};
                if (!code_selected)
                begin
                    if ({pkt_len_reg[15:8], in_byte_reg} == 16'd0)
                    begin
                        phase_next  = psvd_pkg::PH_HUNT;
                        window_next = 16'hFFFF;
                    end
                    else
                    begin
                        skip_left_next = {1'b0, pkt_len_reg[15:8], in_byte_reg};
                        phase_next     = psvd_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    phase_next = psvd_pkg::PH_FLAG1;
                end
            end
            psvd_pkg::PH_FLAG1:
            begin
                // Without the extension flags this byte starts a skip of
                // five bytes plus the packet length.
                if (!in_byte_reg[7])
                begin
                    skip_left_next = len_ext + psvd_pkg::NOEXT_EXTRA;
                    phase_next     = psvd_pkg::PH_SKIP;
                end
                else
                begin
                    phase_next = psvd_pkg::PH_FLAG2;
                end
            end
            psvd_pkg::PH_FLAG2:
            begin
                phase_next = psvd_pkg::PH_HLEN;
            end
            psvd_pkg::PH_HLEN:
            begin
                pay_left_next = pay_from_hlen;
                if (in_byte_reg != 8'd0)
                begin
                    skip_left_next = {9'd0, in_byte_reg};
                    phase_next     = psvd_pkg::PH_HDR;
                end
                else if (pay_from_hlen == 16'd0)
                begin
                    phase_next  = psvd_pkg::PH_HUNT;
                    window_next = 16'hFFFF;
                end
                else
                begin
                    first_pend_next = 1'b1;
                    phase_next      = psvd_pkg::PH_PAYLOAD;
                end
            end
            psvd_pkg::PH_HDR:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 17'd0)
                begin
                    if (pay_left_reg == 16'd0)
                    begin
                        phase_next  = psvd_pkg::PH_HUNT;
                        window_next = 16'hFFFF;
                    end
                    else
                    begin
                        first_pend_next = 1'b1;
                        phase_next      = psvd_pkg::PH_PAYLOAD;
                    end
                end
            end
            psvd_pkg::PH_PAYLOAD:
            begin
                emit            = 1'b1;
                first_pend_next = 1'b0;
                if (pay_left_reg <= 16'd1)
                begin
                    pay_left_next = 16'd0;
                    phase_next    = psvd_pkg::PH_HUNT;
                    window_next   = 16'hFFFF;
                end
                else
                begin
                    pay_left_next = pay_left_reg - 16'd1;
                end
            end
            psvd_pkg::PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == 17'd0)
                begin
                    phase_next  = psvd_pkg::PH_HUNT;
                    window_next = 16'hFFFF;
                end
            end
            default:
            begin
                // Hunting for 00 00 01; unused codes behave the same.
                if (window_reg == 16'd0 && in_byte_reg == 8'd1)
                begin
                    phase_next = psvd_pkg::PH_CODE;
                end
                else
                begin
                    phase_next  = psvd_pkg::PH_HUNT;
                    window_next = {window_reg[7:0], in_byte_reg};
                end
            end
        endcase

        // The last byte of a buffer drops everything after it is handled.
        if (in_last_reg)
        begin
            phase_next      = psvd_pkg::PH_HUNT;
            window_next     = 16'hFFFF;
            skip_left_next  = 17'd0;
            pkt_len_next    = 16'd0;
            code_next       = 8'd0;
            pay_left_next   = 16'd0;
            first_pend_next = 1'b0;
        end
    end

    // Parser state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= psvd_pkg::PH_HUNT;
            window_reg     <= 16'hFFFF;
            skip_left_reg  <= 17'd0;
            pkt_len_reg    <= 16'd0;
            code_reg       <= 8'd0;
            pay_left_reg   <= 16'd0;
            first_pend_reg <= 1'b0;
        end
        else if (proc)
        begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            skip_left_reg  <= skip_left_next;
            pkt_len_reg    <= pkt_len_next;
            code_reg       <= code_next;
            pay_left_reg   <= pay_left_next;
            first_pend_reg <= first_pend_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            out_byte_reg  <= in_byte_reg;
            out_code_reg  <= code_reg;
            out_first_reg <= first_pend_reg;
            out_last_reg  <= (pay_left_reg == 16'd1);
        end
    end

    // An empty output register never holds back the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty output register");

    // A payload byte that is parsed always produces a result on m_tvalid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && phase_reg == psvd_pkg::PH_PAYLOAD) |=> m_tvalid)
        else $error("payload byte parsed without a result");

    // The payload phase always has bytes left to give.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == psvd_pkg::PH_PAYLOAD) |-> (pay_left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    // The skip phase always has bytes left to skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == psvd_pkg::PH_SKIP) |-> (skip_left_reg != 17'd0))
        else $error("skip phase with zero count");

endmodule
